/* design/bounded_ordered_list_assert.svh */
// Assertion helpers used by the list datapath.
`ifndef BOUNDED_ORDERED_LIST_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ASSERT_SVH

// Condition must hold at every edge out of reset.
`define BOL_ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define BOL_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* design/bol_pkg.sv */
`default_nettype none

package bol_pkg;

    localparam int DEF_CAPACITY = 16;

    localparam int MODE_W   = 3;
    localparam int POS_W    = 4;
    localparam int ELEM_W   = 8;
    localparam int STATUS_W = 3;
    localparam int FOUND_W  = 4;
    localparam int COUNT_W  = 5;

    localparam logic [ELEM_W-1:0] SPACE_CHAR = 8'd32;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND    = 3'd0,
        MODE_OVERWRITE = 3'd1,
        MODE_REMOVE    = 3'd2,
        MODE_READ      = 3'd3,
        MODE_SEARCH    = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_EMPTY    = 3'd2,
        STAT_RANGE    = 3'd3,
        STAT_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SEARCH,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_APPEND,
        WR_POS,
        WR_SHIFT
    } wr_sel_t;

    typedef enum logic [1:0] {
        RD_HOLD,
        RD_POS,
        RD_NEXT,
        RD_FIRST
    } rd_sel_t;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_POS,
        IDX_INC
    } idx_op_t;

    typedef enum logic [1:0] {
        OCC_HOLD,
        OCC_INC,
        OCC_DEC
    } occ_op_t;

    typedef enum logic [1:0] {
        DATA_ZERO,
        DATA_SPACE,
        DATA_MEM
    } data_sel_t;

    typedef struct packed {
        logic      idle;
        wr_sel_t   wr_sel;
        rd_sel_t   rd_sel;
        idx_op_t   idx_op;
        occ_op_t   occ_op;
        logic      res_we;
        status_t   res_status;
        data_sel_t res_data;
        logic      res_found;
        logic      push;
    } cmd_t;

    typedef struct packed {
        logic  req_valid;
        mode_t mode;
        logic  empty;
        logic  full;
        logic  pos_bad;
        logic  idx_last;
        logic  match;
        logic  out_busy;
    } stat_t;

endpackage

`default_nettype wire

/* design/bol_if.sv */
`default_nettype none

interface bol_req_if;
    import bol_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic [ELEM_W-1:0] element;

    modport source (output valid, mode, position, element, input ready);
    modport sink   (input valid, mode, position, element, output ready);
endinterface

interface bol_rsp_if;
    import bol_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ELEM_W-1:0]   read_data;
    logic [FOUND_W-1:0]  found_index;
    logic [COUNT_W-1:0]  entry_count;
    logic                is_empty;
    logic                is_full;

    modport source (output valid, status, read_data, found_index, entry_count,
                    is_empty, is_full, input ready);
    modport sink   (input valid, status, read_data, found_index, entry_count,
                    is_empty, is_full, output ready);
endinterface

`default_nettype wire

/* design/bol_ctrl.sv */
`default_nettype none

module bol_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire bol_pkg::stat_t stat,
    output bol_pkg::cmd_t       cmd
);
    import bol_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.idle       = 1'b0;
        cmd.wr_sel     = WR_NONE;
        cmd.rd_sel     = RD_HOLD;
        cmd.idx_op     = IDX_HOLD;
        cmd.occ_op     = OCC_HOLD;
        cmd.res_we     = 1'b0;
        cmd.res_status = STAT_OK;
        cmd.res_data   = DATA_ZERO;
        cmd.res_found  = 1'b0;
        cmd.push       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd.idle = 1'b1;
                if (stat.req_valid)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                // error cases, append, overwrite and unused modes finish here
                cmd.res_we = 1'b1;
                state_next = S_DONE;
                unique case (stat.mode)
                    MODE_APPEND:
                    begin
                        if (stat.full)
                        begin
                            cmd.res_status = STAT_FULL;
                        end
                        else
                        begin
                            cmd.wr_sel = WR_APPEND;
                            cmd.occ_op = OCC_INC;
                        end
                    end
                    MODE_OVERWRITE:
                    begin
                        if (stat.empty)
                        begin
                            cmd.res_status = STAT_EMPTY;
                        end
                        else if (stat.pos_bad)
                        begin
                            cmd.res_status = STAT_RANGE;
                        end
                        else
                        begin
                            cmd.wr_sel = WR_POS;
                        end
                    end
                    MODE_REMOVE:
                    begin
                        if (stat.empty)
                        begin
                            cmd.res_status = STAT_EMPTY;
                        end
                        else if (stat.pos_bad)
                        begin
                            cmd.res_status = STAT_RANGE;
                        end
                        else
                        begin
                            cmd.res_we = 1'b0;
                            cmd.idx_op = IDX_POS;
                            state_next = S_SHIFT_RD;
                        end
                    end
                    MODE_READ:
                    begin
                        if (stat.empty)
                        begin
                            cmd.res_status = STAT_EMPTY;
                            cmd.res_data   = DATA_SPACE;
                        end
                        else if (stat.pos_bad)
                        begin
                            cmd.res_status = STAT_RANGE;
                            cmd.res_data   = DATA_SPACE;
                        end
                        else
                        begin
                            cmd.res_we = 1'b0;
                            cmd.rd_sel = RD_POS;
                            state_next = S_READ;
                        end
                    end
                    MODE_SEARCH:
                    begin
                        if (stat.empty)
                        begin
                            cmd.res_status = STAT_EMPTY;
                        end
                        else
                        begin
                            cmd.res_we = 1'b0;
                            cmd.rd_sel = RD_FIRST;
                            cmd.idx_op = IDX_ZERO;
                            state_next = S_SEARCH;
                        end
                    end
                    default:
                    begin
                        // unused codes: report count and flags only
                        cmd.res_status = STAT_OK;
                    end
                endcase
            end

            S_READ:
            begin
                cmd.res_we   = 1'b1;
                cmd.res_data = DATA_MEM;
                state_next   = S_DONE;
            end

            S_SEARCH:
            begin
                // read data belongs to entry idx
                if (stat.match)
                begin
                    cmd.res_we    = 1'b1;
                    cmd.res_found = 1'b1;
                    state_next    = S_DONE;
                end
                else if (stat.idx_last)
                begin
                    cmd.res_we     = 1'b1;
                    cmd.res_status = STAT_NOTFOUND;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.rd_sel = RD_NEXT;
                    cmd.idx_op = IDX_INC;
                end
            end

            S_SHIFT_RD:
            begin
                if (stat.idx_last)
                begin
                    cmd.occ_op = OCC_DEC;
                    cmd.res_we = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_sel = RD_NEXT;
                    state_next = S_SHIFT_WR;
                end
            end

            S_SHIFT_WR:
            begin
                cmd.wr_sel = WR_SHIFT;
                cmd.idx_op = IDX_INC;
                state_next = S_SHIFT_RD;
            end

            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/bol_datapath.sv */
`default_nettype none
`include "bounded_ordered_list_assert.svh"

module bol_datapath #(
    parameter int CAPACITY = bol_pkg::DEF_CAPACITY
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    bol_req_if.sink            req,
    bol_rsp_if.source          rsp,
    input  wire bol_pkg::cmd_t cmd,
    output bol_pkg::stat_t     stat
);
    import bol_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int OW   = $clog2(CAPACITY + 1);
    localparam int CMPW = AW + 1;

    localparam logic [OW-1:0] OCC_MAX = OW'(CAPACITY);

    logic [ELEM_W-1:0] mem [CAPACITY];

    logic [MODE_W-1:0]   req_mode_reg;
    logic [POS_W-1:0]    req_pos_reg;
    logic [ELEM_W-1:0]   req_elem_reg;
    logic [OW-1:0]       occ_reg;
    logic [OW-1:0]       occ_next;
    logic [AW-1:0]       idx_reg;
    logic [AW-1:0]       idx_next;
    logic [ELEM_W-1:0]   rd_data_reg;
    status_t             res_status_reg;
    logic [ELEM_W-1:0]   res_data_reg;
    logic [FOUND_W-1:0]  res_found_reg;
    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [ELEM_W-1:0]   out_data_reg;
    logic [FOUND_W-1:0]  out_found_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic                out_empty_reg;
    logic                out_full_reg;

    logic                load;
    logic [AW-1:0]       pos_addr;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic [ELEM_W-1:0]   wr_data;
    logic                wr_en;
    logic [CMPW-1:0]     idx_succ;
    logic [ELEM_W-1:0]   res_data_mux;
    logic                occ_empty;
    logic                occ_full;

    assign load      = req.valid && cmd.idle;
    assign req.ready = cmd.idle;
    assign pos_addr  = AW'(req_pos_reg);
    assign idx_succ  = CMPW'(idx_reg) + CMPW'(1);
    assign occ_empty = (occ_reg == '0);
    assign occ_full  = (occ_reg == OCC_MAX);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_mode_reg <= req.mode;
            req_pos_reg  <= req.position;
            req_elem_reg <= req.element;
        end
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RD_POS:   rd_addr = pos_addr;
            RD_NEXT:  rd_addr = idx_reg + AW'(1);
            RD_FIRST: rd_addr = '0;
            default:  rd_addr = idx_reg;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = idx_reg;
        wr_data = req_elem_reg;
        case (cmd.wr_sel)
            WR_APPEND: wr_addr = AW'(occ_reg);
            WR_POS:    wr_addr = pos_addr;
            WR_SHIFT:  wr_data = rd_data_reg;
            default:   wr_en   = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_comb
    begin
        case (cmd.idx_op)
            IDX_ZERO: idx_next = '0;
            IDX_POS:  idx_next = pos_addr;
            IDX_INC:  idx_next = idx_reg + AW'(1);
            default:  idx_next = idx_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
    end

    always_comb
    begin
        case (cmd.occ_op)
            OCC_INC: occ_next = occ_reg + OW'(1);
            OCC_DEC: occ_next = occ_reg - OW'(1);
            default: occ_next = occ_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_comb
    begin
        case (cmd.res_data)
            DATA_SPACE: res_data_mux = SPACE_CHAR;
            DATA_MEM:   res_data_mux = rd_data_reg;
            default:    res_data_mux = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_we)
        begin
            res_status_reg <= cmd.res_status;
            res_data_reg   <= res_data_mux;
            res_found_reg  <= cmd.res_found ? FOUND_W'(idx_reg) : '0;
        end
    end

    // output register: the next request is taken while a result waits here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_status_reg <= res_status_reg;
            out_data_reg   <= res_data_reg;
            out_found_reg  <= res_found_reg;
            out_count_reg  <= COUNT_W'(occ_reg);
            out_empty_reg  <= occ_empty;
            out_full_reg   <= occ_full;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.read_data   = out_data_reg;
    assign rsp.found_index = out_found_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.is_empty    = out_empty_reg;
    assign rsp.is_full     = out_full_reg;

    assign stat.req_valid = req.valid;
    assign stat.mode      = mode_t'(req_mode_reg);
    assign stat.empty     = occ_empty;
    assign stat.full      = occ_full;
    assign stat.pos_bad   = {{OW{1'b0}}, req_pos_reg} >= {{POS_W{1'b0}}, occ_reg};
    assign stat.idx_last  = idx_succ >= CMPW'(occ_reg);
    assign stat.match     = (rd_data_reg == req_elem_reg);
    assign stat.out_busy  = out_valid_reg && !rsp.ready;

    `BOL_ASSERT_ALWAYS(a_occ_bound, clk, rst_n, occ_reg <= OCC_MAX, "occupancy above capacity")
    `BOL_ASSERT_IMPLY(a_append_room, clk, rst_n, cmd.wr_sel == WR_APPEND, !occ_full,
                      "append while full")
    `BOL_ASSERT_IMPLY(a_push_free, clk, rst_n, cmd.push, !stat.out_busy,
                      "result pushed over a held beat")
    `BOL_ASSERT_IMPLY(a_shift_range, clk, rst_n, cmd.wr_sel == WR_SHIFT,
                      idx_succ < CMPW'(occ_reg), "shift past last entry")

endmodule

`default_nettype wire

/* design/bounded_ordered_list.sv */
// Bounded ordered list of bytes with CAPACITY entries.
// req channel: one beat per request (mode, position, element); modes are
// append, overwrite, remove, read and search. rsp channel: exactly one beat
// per request with status, read_data, found_index, entry_count, is_empty
// and is_full; entry_count and the flags reflect the list after the request.
// Requests are handled one at a time by a small sequencer over a single
// one-write/one-read entry memory with registered read data.
// Each request runs IDLE, EXEC and DONE; append, overwrite, unused modes
// and any error need nothing more. Read adds a READ state after EXEC.
// Search walks the entries in SEARCH until a match or the last of them
// (1..count entries examined). Remove moves each of the count - 1 - position
// later entries down one place through SHIFT_RD and SHIFT_WR, then ends on SHIFT_RD.
// The shift and scan loops run through the single memory port.
// The result beat turns valid as the sequencer returns to IDLE, so a ready
// receiver takes it at the same edge that can accept the next request.
// The result sits in an output register: the next request is accepted while
// it waits; a stalled receiver only holds up the request after that.
// Reset (rst_n low, asynchronous) empties the list at once; entries are not
// cleared, as data is only ever used from occupied positions.
`default_nettype none

module bounded_ordered_list #(
    parameter int CAPACITY = bol_pkg::DEF_CAPACITY
) (
    input wire logic  clk,
    input wire logic  rst_n,
    bol_req_if.sink   req,
    bol_rsp_if.source rsp
);
    import bol_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    bol_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    bol_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule

`default_nettype wire

/* verif/bounded_ordered_list_checker.sv */
`default_nettype none

module bounded_ordered_list_checker #(
    parameter int CAPACITY = bol_pkg::DEF_CAPACITY
) (
    input  wire logic clk,
    input  wire logic rst_n,
    bol_req_if        req,
    bol_rsp_if        rsp,
    output int        fail_count,
    output int        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import bol_pkg::*;

    typedef struct packed {
        status_t             status;
        logic [ELEM_W-1:0]   read_data;
        logic [FOUND_W-1:0]  found_index;
        logic [COUNT_W-1:0]  entry_count;
        logic                is_empty;
        logic                is_full;
    } list_result_t;

    logic [ELEM_W-1:0] entries [CAPACITY];
    int                occupancy;
    list_result_t      pending_results [$];
    int                errors;

    // Applies one request to the shadow list and returns the result it owes.
    function automatic list_result_t apply_request(input logic [MODE_W-1:0] mode,
                                                   input logic [POS_W-1:0]  pos,
                                                   input logic [ELEM_W-1:0] elem);
        list_result_t res;
        int           i;
        int           p;
        res = '0;
        res.status = STAT_OK;
        p = int'(pos);
        case (mode)
            MODE_APPEND:
                if (occupancy >= CAPACITY)
                    res.status = STAT_FULL;
                else
                begin
                    entries[occupancy] = elem;
                    occupancy++;
                end
            MODE_OVERWRITE:
                if (occupancy == 0)
                    res.status = STAT_EMPTY;
                else if (p >= occupancy)
                    res.status = STAT_RANGE;
                else
                    entries[p] = elem;
            MODE_REMOVE:
                if (occupancy == 0)
                    res.status = STAT_EMPTY;
                else if (p >= occupancy)
                    res.status = STAT_RANGE;
                else
                begin
                    for (i = p; i + 1 < occupancy; i++)
                        entries[i] = entries[i + 1];
                    occupancy--;
                end
            MODE_READ:
                if (occupancy == 0)
                begin
                    res.status = STAT_EMPTY;
                    res.read_data = SPACE_CHAR;
                end
                else if (p >= occupancy)
                begin
                    res.status = STAT_RANGE;
                    res.read_data = SPACE_CHAR;
                end
                else
                    res.read_data = entries[p];
            MODE_SEARCH:
                if (occupancy == 0)
                    res.status = STAT_EMPTY;
                else
                begin
                    res.status = STAT_NOTFOUND;
                    for (i = 0; i < occupancy; i++)
                    begin
                        if (entries[i] == elem)
                        begin
                            res.status = STAT_OK;
                            res.found_index = i[FOUND_W-1:0];
                            break;
                        end
                    end
                end
            default:
                ; // unused codes only report the count and flags
        endcase
        res.entry_count = occupancy[COUNT_W-1:0];
        res.is_empty = (occupancy == 0);
        res.is_full = (occupancy >= CAPACITY);
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        list_result_t want;
        if (!rst_n)
        begin
            occupancy = 0;
            pending_results.delete();
            errors = 0;
            fail_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            // results first: a beat accepted now always belongs to an older request
            if (rsp.valid && rsp.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: extra result beat, expected none, got status %0d count %0d",
                             $time, rsp.status, rsp.entry_count);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(rsp.status));
                    check_field("read_data", 32'(want.read_data), 32'(rsp.read_data));
                    check_field("found_index", 32'(want.found_index),
                                32'(rsp.found_index));
                    check_field("entry_count", 32'(want.entry_count),
                                32'(rsp.entry_count));
                    check_field("is_empty", 32'(want.is_empty), 32'(rsp.is_empty));
                    check_field("is_full", 32'(want.is_full), 32'(rsp.is_full));
                end
            end
            if (req.valid && req.ready)
                pending_results.push_back(apply_request(req.mode, req.position, req.element));
            fail_count <= errors;
            outstanding <= pending_results.size();
        end
    end

endmodule

`default_nettype wire

/* verif/bounded_ordered_list_test.sv */
`default_nettype none

module bounded_ordered_list_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bol_pkg::*;

    localparam int RANDOM_ITEMS = 740;
    localparam int STALL_AFTER = 200;
    localparam int LONG_STALL_CYCLES = 250;
    localparam int TAIL_CYCLES = 40;
    localparam int IDLE_LIMIT = 3000;

    localparam logic [MODE_W-1:0] MODE_FIRST_UNUSED = 3'd5;
    localparam logic [MODE_W-1:0] MODE_LAST_UNUSED = 3'd7;

    typedef enum int {
        FILL_MIX,
        DRAIN_MIX,
        BALANCED_MIX
    } traffic_mix_t;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   outstanding;
    int   sent_count = 0;
    int   idle_cycles = 0;

    // two copies of 8'h5a so a search has to stop at the first one
    logic [ELEM_W-1:0] fill_bytes [16] = '{8'h00, 8'hff, 8'h01, 8'h5a, 8'h80, 8'h7f, 8'haa, 8'h55,
                                           8'h10, 8'h5a, 8'hfe, 8'h02, 8'h40, 8'h20, 8'h08, 8'hc3};

    bol_req_if req_ch ();
    bol_rsp_if rsp_ch ();

    bounded_ordered_list dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    bounded_ordered_list_checker result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode(input traffic_mix_t mix);
        int r;
        int w_append;
        int w_remove;
        r = $urandom_range(0, 99);
        case (mix)
            FILL_MIX:  begin w_append = 50; w_remove = 12; end
            DRAIN_MIX: begin w_append = 15; w_remove = 35; end
            default:   begin w_append = 25; w_remove = 20; end
        endcase
        if (r < w_append)
            return MODE_APPEND;
        else if (r < w_append + w_remove)
            return MODE_REMOVE;
        else if (r >= 96)
            return MODE_W'($urandom_range(MODE_FIRST_UNUSED, MODE_LAST_UNUSED));
        case ($urandom_range(0, 2))
            0:       return MODE_READ;
            1:       return MODE_SEARCH;
            default: return MODE_OVERWRITE;
        endcase
    endfunction

    // low positions often, since the list is short much of the time
    function automatic logic [POS_W-1:0] pick_position();
        if ($urandom_range(0, 1))
            return POS_W'($urandom_range(0, 3));
        return POS_W'($urandom_range(0, 15));
    endfunction

    // a small alphabet half the time so searches hit
    function automatic logic [ELEM_W-1:0] pick_element();
        if ($urandom_range(0, 1))
            return ELEM_W'($urandom_range(0, 7));
        return ELEM_W'($urandom_range(0, 255));
    endfunction

    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                             input logic [ELEM_W-1:0] elem, input int gap);
        req_ch.valid <= 1'b1;
        req_ch.mode <= mode;
        req_ch.position <= pos;
        req_ch.element <= elem;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sent_count++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        traffic_mix_t mix;
        int           mix_left;
        bit           no_gaps;
        int           n;

        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.mode <= MODE_APPEND;
        req_ch.position <= '0;
        req_ch.element <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reads, searches, overwrites and removes on an empty list are refused
        send_item(MODE_READ, 4'd0, 8'h00, pick_gap());
        send_item(MODE_SEARCH, 4'd0, 8'h5a, pick_gap());
        send_item(MODE_OVERWRITE, 4'd0, 8'h11, pick_gap());
        send_item(MODE_REMOVE, 4'd0, 8'h00, pick_gap());
        send_item(MODE_LAST_UNUSED, 4'd15, 8'hff, pick_gap());
        for (n = 0; n < 16; n++)
            send_item(MODE_APPEND, 4'(n), fill_bytes[n], pick_gap());
        send_item(MODE_APPEND, 4'd0, 8'h77, pick_gap());
        send_item(MODE_SEARCH, 4'd0, 8'h5a, pick_gap());
        send_item(MODE_OVERWRITE, 4'd15, 8'h99, pick_gap());
        send_item(MODE_READ, 4'd15, 8'h00, pick_gap());
        // remove at the head shifts every other entry
        send_item(MODE_REMOVE, 4'd0, 8'h00, pick_gap());
        send_item(MODE_READ, 4'd15, 8'h00, pick_gap());
        send_item(MODE_SEARCH, 4'd0, 8'hee, pick_gap());
        drain_results();

        mix_left = 0;
        mix = BALANCED_MIX;
        no_gaps = 1'b0;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (mix_left == 0)
            begin
                mix = traffic_mix_t'($urandom_range(0, 2));
                no_gaps = ($urandom_range(0, 3) == 0);
                mix_left = $urandom_range(20, 60);
            end
            mix_left--;
            if (n == RANDOM_ITEMS / 2)
                drain_results();
            send_item(pick_mode(mix), pick_position(), pick_element(),
                      no_gaps ? 0 : pick_gap());
        end

        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("bounded_ordered_list_test passed");
        else
            $display("bounded_ordered_list_test failed");
        $finish;
    end

    // result side back-pressure, with one long hold-off to fill the block up
    initial
    begin
        int run_left;
        bit ready_now;
        bit long_stall_done;

        run_left = 0;
        ready_now = 1'b0;
        long_stall_done = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!long_stall_done && sent_count >= STALL_AFTER)
            begin
                long_stall_done = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_STALL_CYCLES) @(posedge clk);
                ready_now = 1'b0;
                run_left = 0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    ready_now = !ready_now;
                    run_left = ready_now ? $urandom_range(1, 40) : pick_gap() + 1;
                end
                run_left--;
                rsp_ch.ready <= ready_now;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
                $display("bounded_ordered_list_test failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

`default_nettype wire
